FILE: hw/rtl/lcdwf_pkg.sv
// package for the character lcd write formatter
// types, codes and constants shared by the front, queue, back and top files
`default_nettype none

package lcdwf_pkg;

  localparam int MaxDigitsDef = 10;
  // a non-negative 32-bit signed value never has more than ten decimal digits
  localparam int NumDigits    = 10;
  localparam int QueueDepth   = 2;

  localparam logic [2:0] ModeCmd    = 3'd0;
  localparam logic [2:0] ModeChar   = 3'd1;
  localparam logic [2:0] ModeGoto   = 3'd2;
  localparam logic [2:0] ModeNumber = 3'd3;
  localparam logic [2:0] ModeInit   = 3'd4;

  localparam logic [7:0] CmdFuncSet = 8'h38;
  localparam logic [7:0] CmdDispOn  = 8'h0C;
  localparam logic [7:0] CmdClear   = 8'h01;
  localparam logic [7:0] DdramSet   = 8'h80;
  localparam logic [7:0] AsciiZero  = 8'h30;

  localparam logic RsInstr = 1'b0;
  localparam logic RsData  = 1'b1;

  typedef enum logic [1:0] {
    JOB_WRITE,
    JOB_NUMBER,
    JOB_INIT
  } job_kind_e;

  typedef struct packed {
    job_kind_e   kind;
    logic        rs;
    logic [7:0]  byte_val;
    logic [30:0] num;
  } job_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_WRITE,
    BK_INIT,
    BK_CONV,
    BK_EMIT
  } bk_state_e;

endpackage

`default_nettype wire

FILE: hw/rtl/lcdwf_front.sv
// front end: classifies one request into a job for the back end
// depends on lcdwf_pkg
`default_nettype none

module lcdwf_front import lcdwf_pkg::*; (
  input  wire logic [2:0]  mode_i,
  input  wire logic [7:0]  byte_value_i,
  input  wire logic [5:0]  column_i,
  input  wire logic        row_i,
  input  wire logic [31:0] number_value_i,
  output logic             keep_o,
  output job_t             job_o
);

  always_comb begin
    keep_o       = 1'b1;
    job_o.kind   = JOB_WRITE;
    job_o.rs     = RsInstr;
    job_o.byte_val = byte_value_i;
    job_o.num    = number_value_i[30:0];
    case (mode_i)
      ModeCmd: begin
        job_o.rs = RsInstr;
      end
      ModeChar: begin
        job_o.rs = RsData;
      end
      ModeGoto: begin
        // row 1 base is 0x40, and the column never reaches it
        job_o.byte_val = DdramSet | {1'b0, row_i, column_i};
      end
      ModeNumber: begin
        job_o.kind = JOB_NUMBER;
        job_o.rs   = RsData;
        // negative values produce no writes
        keep_o     = ~number_value_i[31];
      end
      ModeInit: begin
        job_o.kind = JOB_INIT;
      end
      default: begin
        keep_o = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/lcdwf_queue.sv
// two-entry job queue between front and back end
// depends on lcdwf_pkg
`default_nettype none

module lcdwf_queue import lcdwf_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  wire job_t    job_i,
  input  wire logic    pop_i,
  output job_t         job_o,
  output q_stat_t      stat_o
);

  localparam int PtrW = $clog2(QueueDepth);

  job_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]   count_q, count_d;
  logic            do_push, do_pop;

  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == (PtrW+1)'(QueueDepth));
  assign do_push      = push_i & ~stat_o.full;
  assign do_pop       = pop_i & ~stat_o.empty;
  assign job_o        = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth-1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth-1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/lcdwf_back.sv
// back end: runs one job at a time and drives the registered write stream
// depends on lcdwf_pkg; decimal digits come from a divide-by-ten step per cycle
`default_nettype none

module lcdwf_back import lcdwf_pkg::*; #(
  parameter int MAX_DIGITS = MaxDigitsDef
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire job_t  job_i,
  input  wire logic  q_empty_i,
  output logic       pop_o,
  output logic       idle_o,
  output logic       m_valid_o,
  input  wire logic  m_ready_i,
  output logic       m_rs_o,
  output logic [7:0] m_byte_o,
  output logic       m_last_o
);

  localparam int DigW = $clog2(NumDigits);
  localparam logic [31:0] Recip10 = 32'hCCCCCCCD;

  bk_state_e      state_q, state_d;
  job_t           job_q;
  logic [1:0]     step_q, step_d;
  logic [31:0]    val_q, val_d;
  logic [DigW-1:0] cnt_q, cnt_d;
  logic [DigW-1:0] ptr_q, ptr_d;
  logic [3:0]     dig_q [NumDigits];

  logic [63:0]    prod;
  logic [31:0]    quot;
  logic [31:0]    rem_full;
  logic [3:0]     rem;
  logic [DigW:0]  cnt_next;

  logic           slot_free;
  logic           emit;
  logic           emit_rs;
  logic [7:0]     emit_byte;
  logic           emit_last;
  logic           take_job;
  logic           conv_step;

  logic           out_valid_q;
  logic           out_rs_q;
  logic [7:0]     out_byte_q;
  logic           out_last_q;

  // exact floor division by ten for any 32-bit value
  assign prod     = {32'd0, val_q} * {32'd0, Recip10};
  assign quot     = {3'd0, prod[63:35]};
  assign rem_full = val_q - ((quot << 3) + (quot << 1));
  assign rem      = rem_full[3:0];
  assign cnt_next = {1'b0, cnt_q} + 1'b1;

  assign slot_free = ~out_valid_q | m_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (!q_empty_i) begin
          case (job_i.kind)
            JOB_WRITE:  state_d = BK_WRITE;
            JOB_NUMBER: state_d = BK_CONV;
            JOB_INIT:   state_d = BK_INIT;
            default:    state_d = BK_IDLE;
          endcase
        end
      end
      BK_WRITE: begin
        if (slot_free) state_d = BK_IDLE;
      end
      BK_INIT: begin
        if (slot_free && step_q == 2'd2) state_d = BK_IDLE;
      end
      BK_CONV: begin
        if (quot == '0) state_d = BK_EMIT;
      end
      BK_EMIT: begin
        if (slot_free && ptr_q == '0) state_d = BK_IDLE;
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    take_job  = 1'b0;
    conv_step = 1'b0;
    emit      = 1'b0;
    emit_rs   = RsInstr;
    emit_byte = job_q.byte_val;
    emit_last = 1'b0;
    case (state_q)
      BK_IDLE: begin
        take_job = ~q_empty_i;
      end
      BK_WRITE: begin
        emit      = slot_free;
        emit_rs   = job_q.rs;
        emit_last = 1'b1;
      end
      BK_INIT: begin
        emit      = slot_free;
        emit_last = (step_q == 2'd2);
        case (step_q)
          2'd0:    emit_byte = CmdFuncSet;
          2'd1:    emit_byte = CmdDispOn;
          default: emit_byte = CmdClear;
        endcase
      end
      BK_CONV: begin
        conv_step = 1'b1;
      end
      BK_EMIT: begin
        emit      = slot_free;
        emit_rs   = RsData;
        emit_byte = AsciiZero | {4'd0, dig_q[ptr_q]};
        emit_last = (ptr_q == '0);
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_comb begin
    step_d = step_q;
    val_d  = val_q;
    cnt_d  = cnt_q;
    ptr_d  = ptr_q;
    if (take_job) begin
      step_d = 2'd0;
      val_d  = {1'b0, job_i.num};
      cnt_d  = '0;
    end
    if (state_q == BK_INIT && emit) begin
      step_d = step_q + 1'b1;
    end
    if (conv_step) begin
      val_d = quot;
      cnt_d = cnt_next[DigW-1:0];
      // keep only the lowest MAX_DIGITS digits
      if (int'(cnt_next) > MAX_DIGITS) begin
        ptr_d = DigW'(MAX_DIGITS - 1);
      end else begin
        ptr_d = cnt_q;
      end
    end
    if (state_q == BK_EMIT && emit && ptr_q != '0) begin
      ptr_d = ptr_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (slot_free) begin
        out_valid_q <= emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    step_q <= step_d;
    val_q  <= val_d;
    cnt_q  <= cnt_d;
    ptr_q  <= ptr_d;
    if (take_job) begin
      job_q <= job_i;
    end
    if (conv_step) begin
      dig_q[cnt_q] <= rem;
    end
    if (emit) begin
      out_rs_q   <= emit_rs;
      out_byte_q <= emit_byte;
      out_last_q <= emit_last;
    end
  end

  assign pop_o     = take_job;
  assign idle_o    = (state_q == BK_IDLE);
  assign m_valid_o = out_valid_q;
  assign m_rs_o    = out_rs_q;
  assign m_byte_o  = out_byte_q;
  assign m_last_o  = out_last_q;

endmodule

`default_nettype wire

FILE: hw/rtl/char_lcd_write_formatter_top.sv
// character lcd write formatter: request stream in, lcd bus write stream out
// a taken request passes the job queue, the back end sequencer and the output register;
// number requests first run one divide-by-ten step per decimal digit (at most ten digits);
// the back end takes a job from the queue only while idle, so later requests wait in the
// queue while it is busy, and each write is held while the receiver is not ready
// reset: asynchronous active low, clears queue pointers, sequencer and output valid
`default_nettype none

module char_lcd_write_formatter_top import lcdwf_pkg::*; #(
  parameter int MAX_DIGITS = MaxDigitsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // byte_value[7:0], column[13:8], row[14], number_value[46:15], zero pad [47]
  input  wire logic [47:0] s_axis_tdata,
  // mode[2:0]
  input  wire logic [2:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // bus_byte[7:0]
  output logic [7:0]       m_axis_tdata,
  // register_select[0]
  output logic             m_axis_tuser,
  output logic             m_axis_tlast
);

  logic    keep;
  job_t    front_job;
  job_t    queue_job;
  q_stat_t q_stat;
  logic    push;
  logic    pop;
  logic    bk_idle;

  lcdwf_front u_front (
    .mode_i         (s_axis_tuser),
    .byte_value_i   (s_axis_tdata[7:0]),
    .column_i       (s_axis_tdata[13:8]),
    .row_i          (s_axis_tdata[14]),
    .number_value_i (s_axis_tdata[46:15]),
    .keep_o         (keep),
    .job_o          (front_job)
  );

  // dropped requests are accepted but never queued
  assign s_axis_tready = ~q_stat.full;
  assign push          = s_axis_tvalid & s_axis_tready & keep;

  lcdwf_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (front_job),
    .pop_i  (pop),
    .job_o  (queue_job),
    .stat_o (q_stat)
  );

  lcdwf_back #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .job_i     (queue_job),
    .q_empty_i (q_stat.empty),
    .pop_o     (pop),
    .idle_o    (bk_idle),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_rs_o    (m_axis_tuser),
    .m_byte_o  (m_axis_tdata),
    .m_last_o  (m_axis_tlast)
  );

`ifndef SYNTH
  a_no_push_when_full: assert property (
    @(posedge clk_i) disable iff (!rst_ni) !(push && q_stat.full)
  ) else $error("job pushed into a full queue");

  a_idle_takes_job: assert property (
    @(posedge clk_i) disable iff (!rst_ni) (bk_idle && !q_stat.empty) |=> !bk_idle
  ) else $error("back end left a queued job waiting");

  a_no_phantom_write: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      (bk_idle && q_stat.empty && !m_axis_tvalid) |=> !m_axis_tvalid
  ) else $error("write appeared with no job in flight");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
// self-checking testbench for char_lcd_write_formatter_top
// predicts the lcd write runs for each request and checks every write on the output stream
// depends on lcdwf_pkg and the formatter rtl
`timescale 1ns / 100ps

module tb_top;
  import lcdwf_pkg::*;

  localparam logic [7:0] Row1Base     = 8'h40;
  localparam logic [2:0] ModeUnusedLo = 3'd5;
  localparam logic [2:0] ModeUnusedHi = 3'd7;
  localparam int         SettleCycles = 40;

  typedef struct {
    logic       rs;
    logic [7:0] bus_byte;
    logic       last;
  } lcd_write_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  lcd_write_t pending_writes[$];
  int mismatches     = 0;
  int requests_sent  = 0;
  int requests_muted = 0;
  int writes_checked = 0;
  int idle_pct       = 0;
  int stall_pct      = 0;
  int hold_len       = 0;

  char_lcd_write_formatter_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("mismatch at %0t ns: %s", $time, what);
  endtask

  function automatic void push_write(input logic rs, input logic [7:0] b);
    lcd_write_t w;
    w.rs       = rs;
    w.bus_byte = b;
    w.last     = 1'b0;
    pending_writes.push_back(w);
  endfunction

  // appends the write run that one request should produce
  function automatic int predict_lcd_writes(input logic [2:0] mode, input logic [7:0] bv,
                                            input logic [5:0] col, input logic row,
                                            input logic [31:0] num);
    logic [7:0] digits[$];
    logic [31:0] v;
    int n;
    n = pending_writes.size();
    case (mode)
      ModeCmd:  push_write(RsInstr, bv);
      ModeChar: push_write(RsData, bv);
      ModeGoto: push_write(RsInstr, DdramSet | (row ? ({2'b00, col} + Row1Base) : {2'b00, col}));
      ModeNumber: begin
        v = num;
        if (!v[31]) begin
          if (v == 0) begin
            digits.push_back(AsciiZero);
          end
          while (v != 0) begin
            digits.push_front(AsciiZero + 8'(v % 10));
            v = v / 10;
          end
          // only the lowest digits survive when the value is too long
          while (digits.size() > MaxDigitsDef) void'(digits.pop_front());
          foreach (digits[i]) push_write(RsData, digits[i]);
        end
      end
      ModeInit: begin
        push_write(RsInstr, CmdFuncSet);
        push_write(RsInstr, CmdDispOn);
        push_write(RsInstr, CmdClear);
      end
      default: ;
    endcase
    if (pending_writes.size() > n) pending_writes[$].last = 1'b1;
    return pending_writes.size() - n;
  endfunction

  // offers one request, predicts it once the handshake completes
  task automatic send_request(input logic [2:0] mode, input logic [7:0] bv,
                              input logic [5:0] col, input logic row, input logic [31:0] num);
    if ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, num, row, col, bv};
    s_axis_tuser  <= mode;
    do @(posedge clk_i); while (!s_axis_tready);
    requests_sent++;
    if (predict_lcd_writes(mode, bv, col, row, num) == 0) requests_muted++;
  endtask

  // stop offering and wait for every predicted write
  task automatic drain_writes();
    s_axis_tvalid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_number();
    longint unsigned span;
    case ($urandom_range(9))
      0: return $urandom() | 32'h8000_0000;
      1: return $urandom_range(9);
      2: return 32'h7FFF_FFFF - $urandom_range(3);
      default: begin
        span = 1;
        repeat ($urandom_range(1, 10)) span = span * 10;
        return 32'(longint'($urandom() & 32'h7FFF_FFFF) % span);
      end
    endcase
  endfunction

  // returns 1 when the request should produce at least one write
  task automatic random_request(output bit useful);
    logic [2:0] mode;
    logic [31:0] num;
    int pick;
    pick = $urandom_range(99);
    if (pick < 6) mode = 3'($urandom_range(ModeUnusedLo, ModeUnusedHi));
    else if (pick < 45) mode = ModeNumber;
    else mode = 3'($urandom_range(ModeCmd, ModeInit));
    num = (mode == ModeNumber) ? pick_number() : $urandom();
    useful = (mode <= ModeInit) && !(mode == ModeNumber && num[31]);
    send_request(mode, 8'($urandom()), 6'($urandom()), 1'($urandom()), num);
  endtask

  task automatic test_directed_requests();
    idle_pct  = 0;
    stall_pct = 0;
    send_request(ModeInit, 8'h00, 6'd0, 1'b0, 32'd0);
    send_request(ModeCmd, 8'h00, 6'd0, 1'b0, 32'd0);
    send_request(ModeCmd, 8'hFF, 6'd63, 1'b1, 32'hFFFF_FFFF);
    send_request(ModeChar, 8'h00, 6'd0, 1'b0, 32'd0);
    send_request(ModeChar, 8'hFF, 6'd0, 1'b0, 32'd0);
    send_request(ModeChar, 8'h41, 6'd21, 1'b1, 32'd5);
    send_request(ModeGoto, 8'h00, 6'd0, 1'b0, 32'd0);
    send_request(ModeGoto, 8'hFF, 6'd63, 1'b0, 32'd0);
    send_request(ModeGoto, 8'h00, 6'd0, 1'b1, 32'd0);
    send_request(ModeGoto, 8'hFF, 6'd63, 1'b1, 32'hFFFF_FFFF);
    // zero prints a single digit
    send_request(ModeNumber, 8'h00, 6'd0, 1'b0, 32'd0);
    send_request(ModeNumber, 8'h00, 6'd0, 1'b0, 32'd1);
    send_request(ModeNumber, 8'h00, 6'd0, 1'b0, 32'd9);
    send_request(ModeNumber, 8'h00, 6'd0, 1'b0, 32'd10);
    send_request(ModeNumber, 8'h00, 6'd0, 1'b0, 32'd999_999_999);
    send_request(ModeNumber, 8'h00, 6'd0, 1'b0, 32'd1_000_000_000);
    send_request(ModeNumber, 8'h00, 6'd0, 1'b0, 32'h7FFF_FFFF);
    // negative values are dropped silently
    send_request(ModeNumber, 8'h00, 6'd0, 1'b0, 32'hFFFF_FFFF);
    send_request(ModeNumber, 8'h00, 6'd0, 1'b0, 32'h8000_0000);
    send_request(ModeChar, 8'h5A, 6'd0, 1'b0, 32'd0);
    // unused modes are ignored
    send_request(ModeUnusedLo, 8'hFF, 6'd63, 1'b1, 32'd7);
    send_request(ModeUnusedLo + 3'd1, 8'h00, 6'd0, 1'b0, 32'd7);
    send_request(ModeUnusedHi, 8'hFF, 6'd63, 1'b1, 32'h7FFF_FFFF);
    send_request(ModeInit, 8'h00, 6'd0, 1'b0, 32'd0);
    drain_writes();
  endtask

  task automatic test_random_phase(input int idle, input int stall, input int count);
    int useful_cnt;
    bit useful;
    useful_cnt = 0;
    idle_pct   = idle;
    stall_pct  = stall;
    while (useful_cnt < count) begin
      random_request(useful);
      if (useful) useful_cnt++;
    end
    drain_writes();
  endtask

  // receiver holds off long enough for the block to fill and push back on requests
  task automatic test_output_holdoff();
    bit useful;
    idle_pct  = 0;
    stall_pct = 0;
    @(negedge clk_i);
    hold_len = 120;
    @(posedge clk_i);
    repeat (6) send_request(ModeInit, 8'h00, 6'd0, 1'b0, 32'd0);
    repeat (6) send_request(ModeNumber, 8'h00, 6'd0, 1'b0, 32'h7FFF_FFFF - $urandom_range(99));
    repeat (12) random_request(useful);
    drain_writes();
  endtask

  always @(posedge clk_i) begin
    if (hold_len > 0) begin
      hold_len--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    lcd_write_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_writes.size() == 0) begin
        report_mismatch($sformatf("unexpected write rs=%0b byte=%02h last=%0b",
                                  m_axis_tuser, m_axis_tdata, m_axis_tlast));
      end else begin
        want = pending_writes.pop_front();
        writes_checked++;
        if (m_axis_tuser !== want.rs)
          report_mismatch($sformatf("register select %0b, want %0b", m_axis_tuser, want.rs));
        if (m_axis_tdata !== want.bus_byte)
          report_mismatch($sformatf("bus byte %02h, want %02h", m_axis_tdata, want.bus_byte));
        if (m_axis_tlast !== want.last)
          report_mismatch($sformatf("last %0b, want %0b", m_axis_tlast, want.last));
      end
    end
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d writes outstanding", pending_writes.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_requests();
    test_random_phase(0, 0, 72);
    test_random_phase(51, 0, 72);
    test_random_phase(0, 51, 72);
    test_random_phase(25, 25, 72);
    test_output_holdoff();
    if (pending_writes.size() != 0)
      report_mismatch($sformatf("%0d writes never arrived", pending_writes.size()));
    $display("covered all modes, number extremes, ignored requests and a long output hold-off");
    $display("%0d requests (%0d with no writes), %0d writes checked, %0d mismatches",
             requests_sent, requests_muted, writes_checked, mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/lcdwf_pkg.sv
hw/rtl/lcdwf_front.sv
hw/rtl/lcdwf_queue.sv
hw/rtl/lcdwf_back.sv
hw/rtl/char_lcd_write_formatter_top.sv
tb/sv/tb_top.sv
